// ===== hdl/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Shared constants, control structs and small helper functions.
// ----------------------------------------------------------------------------
package bts_pkg;

	// Defaults for the top-level parameters.
	localparam int STORE_TEXELS_DEF = 65536;
	localparam int FRAC_BITS_DEF    = 16;

	// Fixed field widths.
	localparam int TEXEL_W = 24;
	localparam int INDEX_W = 16;
	localparam int COORD_W = 17;
	localparam int DIM_W   = 9;
	localparam int CHAN_W  = 8;

	// Size of the linear address space a sample can form (row * width + column).
	localparam int LINEAR_SPAN = 65536;

	localparam logic [COORD_W-1:0] COORD_ONE = 17'h10000;
	localparam logic [DIM_W-1:0]   DIM_MAX   = 9'd256;
	localparam logic [DIM_W-1:0]   DIM_MIN   = 9'd1;

	// Item kinds.
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_TEX_WIDTH  = 1'b0;
	localparam logic CFG_TEX_HEIGHT = 1'b1;

	// Color channel codes.
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// Control of the shared multiply-accumulate unit.
	typedef struct packed {
		logic en;
		logic accum;
	} mac_ctl_t;

	// Request to the address wrap unit.
	typedef struct packed {
		logic               start;
		logic [INDEX_W-1:0] value;
	} wrap_req_t;

	// Picks one color byte out of a packed texel.
	function automatic logic [CHAN_W-1:0] chan_byte(input logic [TEXEL_W-1:0] texel,
	                                                input logic [1:0] ch);
		logic [CHAN_W-1:0] b;
		case (ch)
			CH_RED:   b = texel[23:16];
			CH_GREEN: b = texel[15:8];
			CH_BLUE:  b = texel[7:0];
			default:  b = '0;
		endcase
		return b;
	endfunction

	// Limits a texture dimension to the supported range.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0) begin
			r = DIM_MIN;
		end else if (d > DIM_MAX) begin
			r = DIM_MAX;
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage

// ===== hdl/bilinear_texture_sampler.sv =====
// ----------------------------------------------------------------------------
// Bilinear texture sampler
// A write transaction (kind 0) loads one 24-bit RGB texel into the texture
// store; writes can stream one per clock while the block is idle. A
// sample transaction (kind 1) clamps u and v to 1.0, scales them by the
// texture width and height minus one, fetches the four neighbouring texels
// and blends each channel with standard bilinear weights, truncating to
// 8 bits. The scaling, row-base and blend products run through one shared
// multiply-accumulate unit under a small sequencer: two steps for the
// coordinates, two for the row bases and seven per color channel. The four
// texel reads go one at a time through the address wrap unit into a single
// read port. After a sample is accepted, req_stall stays high until the
// sequencer is back in idle, which includes the wait while an earlier
// result still sits in the output register. When STORE_TEXELS is below
// 65536 and not a power of two above one, each of the four addresses is
// reduced modulo the store depth by a reciprocal multiply and one
// correction. The texture store has no reset and must be written before it
// is sampled. Configure tex_width and tex_height only while the block is idle.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler import bts_pkg::*; #(
	parameter int STORE_TEXELS = STORE_TEXELS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,

	// Configuration write port.
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [DIM_W-1:0]   cfg_data,

	// Request channel.
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               kind,
	input  logic [INDEX_W-1:0] texel_index,
	input  logic [CHAN_W-1:0]  texel_red,
	input  logic [CHAN_W-1:0]  texel_green,
	input  logic [CHAN_W-1:0]  texel_blue,
	input  logic [COORD_W-1:0] u_coord,
	input  logic [COORD_W-1:0] v_coord,

	// Response channel.
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [CHAN_W-1:0]  out_red,
	output logic [CHAN_W-1:0]  out_green,
	output logic [CHAN_W-1:0]  out_blue
);

	localparam int AW      = (STORE_TEXELS > 1) ? $clog2(STORE_TEXELS) : 1;
	localparam int WA      = (FRAC_BITS + CHAN_W > COORD_W) ? FRAC_BITS + CHAN_W : COORD_W;
	localparam int WB      = FRAC_BITS + 1;
	localparam int PW      = WA + WB;
	localparam int RES_LSB = 2 * FRAC_BITS;
	localparam int TOP_W   = FRAC_BITS + CHAN_W;

	// Steps of the blend for one channel.
	localparam logic [2:0] BL_TOP_A = 3'd0;
	localparam logic [2:0] BL_TOP_B = 3'd1;
	localparam logic [2:0] BL_BOT_A = 3'd2;
	localparam logic [2:0] BL_BOT_B = 3'd3;
	localparam logic [2:0] BL_MIX_A = 3'd4;
	localparam logic [2:0] BL_MIX_B = 3'd5;
	localparam logic [2:0] BL_STORE = 3'd6;

	localparam logic [1:0] SEL_LAST = 2'd3;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_CU     = 10'b00_0000_0010,
		S_CV     = 10'b00_0000_0100,
		S_ROW0   = 10'b00_0000_1000,
		S_ROW1   = 10'b00_0001_0000,
		S_WSTART = 10'b00_0010_0000,
		S_WRAP   = 10'b00_0100_0000,
		S_FETCH  = 10'b00_1000_0000,
		S_BLEND  = 10'b01_0000_0000,
		S_OUT    = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers and their clamped values.
	logic [DIM_W-1:0] tex_w_q;
	logic [DIM_W-1:0] tex_h_q;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic [DIM_W-1:0] w_m1_full;
	logic [DIM_W-1:0] h_m1_full;
	logic [7:0]       w_m1;
	logic [7:0]       h_m1;

	// Sequencer counters.
	logic [1:0] sel_q;
	logic [1:0] ch_q;
	logic [2:0] step_q;

	// Datapath registers.
	logic [COORD_W-1:0]   uc_q;
	logic [COORD_W-1:0]   vc_q;
	logic [7:0]           x0_q;
	logic [7:0]           x1_q;
	logic [7:0]           y1_q;
	logic [FRAC_BITS-1:0] fx_q;
	logic [FRAC_BITS-1:0] fy_q;
	logic [INDEX_W-1:0]   row0_q;
	logic [INDEX_W-1:0]   row1_q;
	logic [TEXEL_W-1:0]   tex_q [4];
	logic [TOP_W-1:0]     top_q;
	logic [TOP_W-1:0]     bot_q;
	logic [CHAN_W-1:0]    res_red_q;
	logic [CHAN_W-1:0]    res_green_q;
	logic [CHAN_W-1:0]    res_blue_q;
	logic                 rsp_valid_q;

	// Shared unit connections.
	mac_ctl_t      mac_ctl;
	logic [WA-1:0] mac_a;
	logic [WB-1:0] mac_b;
	logic [PW-1:0] acc_q;

	wrap_req_t     wrap_req;
	logic          wrap_done;
	logic [AW-1:0] wrap_addr;

	logic               ram_wr_en;
	logic [AW-1:0]      ram_wr_addr;
	logic [TEXEL_W-1:0] ram_wr_data;
	logic               ram_rd_en;
	logic [TEXEL_W-1:0] ram_rd_data;

	// Handshake helpers.
	logic req_accept;
	logic out_free;

	// Coordinate decode straight from the accumulator.
	logic [7:0]           dec_p0;
	logic [7:0]           dec_p1;
	logic [7:0]           dec_lim;
	logic [39:0]          frac_pad;
	logic [FRAC_BITS-1:0] dec_frac;

	// Blend weights.
	logic [WB-1:0] one_w;
	logic [WB-1:0] wfx;
	logic [WB-1:0] wofx;
	logic [WB-1:0] wfy;
	logic [WB-1:0] wofy;

	// Texel address for the next read.
	logic [1:0]         nxt_sel;
	logic [7:0]         addr_x;
	logic [INDEX_W-1:0] addr_row;

	assign w_eff     = clamp_dim(tex_w_q);
	assign h_eff     = clamp_dim(tex_h_q);
	assign w_m1_full = w_eff - DIM_MIN;
	assign h_m1_full = h_eff - DIM_MIN;
	assign w_m1      = w_m1_full[7:0];
	assign h_m1      = h_m1_full[7:0];

	assign req_stall  = (state_q != S_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign rsp_valid  = rsp_valid_q;

	// The scaled coordinate has its texel position in bits 23..16 and its
	// fraction in bits 15..0. The fraction is cut or padded to FRAC_BITS.
	// At exactly 1.0 the position is already the last texel and the fraction
	// is zero, so the neighbour clamp alone covers that case.
	assign dec_lim  = (state_q == S_CV) ? w_m1 : h_m1;
	assign dec_p0   = acc_q[23:16];
	assign dec_p1   = (dec_p0 == dec_lim) ? dec_p0 : dec_p0 + 8'd1;
	assign frac_pad = {acc_q[15:0], 24'd0};
	assign dec_frac = frac_pad[39 -: FRAC_BITS];

	assign one_w = WB'(1) << FRAC_BITS;
	assign wfx   = WB'(fx_q);
	assign wofx  = one_w - wfx;
	assign wfy   = WB'(fy_q);
	assign wofy  = one_w - wfy;

	// Texel order: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1).
	assign nxt_sel  = (state_q == S_WSTART) ? 2'd0 : sel_q + 2'd1;
	assign addr_x   = nxt_sel[0] ? x1_q : x0_q;
	assign addr_row = nxt_sel[1] ? row1_q : row0_q;

	always_comb begin
		wrap_req.start = (state_q == S_WSTART) || ((state_q == S_FETCH) && (sel_q != SEL_LAST));
		wrap_req.value = addr_row + INDEX_W'(addr_x);
	end

	// Texture store ports: writes are taken only in idle, reads follow the wrap unit.
	assign ram_wr_en   = req_accept && (kind == KIND_WRITE) && (32'(texel_index) < STORE_TEXELS);
	assign ram_wr_addr = AW'(texel_index);
	assign ram_wr_data = {texel_red, texel_green, texel_blue};
	assign ram_rd_en   = (state_q == S_WRAP) && wrap_done;

	// Operand selection for the shared multiply-accumulate unit.
	always_comb begin
		mac_ctl = '0;
		mac_a   = '0;
		mac_b   = '0;
		unique case (state_q)
			S_CU: begin
				mac_ctl.en = 1'b1;
				mac_a      = WA'(uc_q);
				mac_b      = WB'(w_m1);
			end
			S_CV: begin
				mac_ctl.en = 1'b1;
				mac_a      = WA'(vc_q);
				mac_b      = WB'(h_m1);
			end
			S_ROW0: begin
				// Row base of y0; y0 is still in the accumulator this cycle.
				mac_ctl.en = 1'b1;
				mac_a      = WA'(dec_p0);
				mac_b      = WB'(w_eff);
			end
			S_ROW1: begin
				mac_ctl.en = 1'b1;
				mac_a      = WA'(y1_q);
				mac_b      = WB'(w_eff);
			end
			S_BLEND: begin
				unique case (step_q)
					BL_TOP_A: begin
						mac_ctl.en = 1'b1;
						mac_a      = WA'(chan_byte(tex_q[0], ch_q));
						mac_b      = wofx;
					end
					BL_TOP_B: begin
						mac_ctl = '{en: 1'b1, accum: 1'b1};
						mac_a   = WA'(chan_byte(tex_q[1], ch_q));
						mac_b   = wfx;
					end
					BL_BOT_A: begin
						mac_ctl.en = 1'b1;
						mac_a      = WA'(chan_byte(tex_q[2], ch_q));
						mac_b      = wofx;
					end
					BL_BOT_B: begin
						mac_ctl = '{en: 1'b1, accum: 1'b1};
						mac_a   = WA'(chan_byte(tex_q[3], ch_q));
						mac_b   = wfx;
					end
					BL_MIX_A: begin
						mac_ctl.en = 1'b1;
						mac_a      = WA'(top_q);
						mac_b      = wofy;
					end
					BL_MIX_B: begin
						mac_ctl = '{en: 1'b1, accum: 1'b1};
						mac_a   = WA'(bot_q);
						mac_b   = wfy;
					end
					default: begin
						mac_ctl = '0;
					end
				endcase
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	// Sequencer, configuration and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= '0;
			ch_q        <= '0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
			tex_w_q     <= DIM_MAX;
			tex_h_q     <= DIM_MAX;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TEX_WIDTH:  tex_w_q <= cfg_data;
					CFG_TEX_HEIGHT: tex_h_q <= cfg_data;
				endcase
			end

			// A new result loads the output register once it is free; a held
			// result stays until the receiver takes it.
			rsp_valid_q <= ((state_q == S_OUT) && out_free) || (rsp_valid_q && rsp_stall);

			unique case (state_q)
				S_IDLE: begin
					if (req_accept && (kind == KIND_SAMPLE)) begin
						state_q <= S_CU;
						sel_q   <= '0;
					end
				end
				S_CU:     state_q <= S_CV;
				S_CV:     state_q <= S_ROW0;
				S_ROW0:   state_q <= S_ROW1;
				S_ROW1:   state_q <= S_WSTART;
				S_WSTART: state_q <= S_WRAP;
				S_WRAP: begin
					if (wrap_done) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					if (sel_q == SEL_LAST) begin
						state_q <= S_BLEND;
						ch_q    <= CH_RED;
						step_q  <= BL_TOP_A;
					end else begin
						state_q <= S_WRAP;
						sel_q   <= sel_q + 2'd1;
					end
				end
				S_BLEND: begin
					if (step_q == BL_STORE) begin
						step_q <= BL_TOP_A;
						if (ch_q == CH_BLUE) begin
							state_q <= S_OUT;
						end else begin
							ch_q <= ch_q + 2'd1;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_OUT: begin
					// The result waits here only while the output register is full.
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath captures.
	always_ff @(posedge clk) begin
		if (req_accept && (kind == KIND_SAMPLE)) begin
			uc_q <= (u_coord > COORD_ONE) ? COORD_ONE : u_coord;
			vc_q <= (v_coord > COORD_ONE) ? COORD_ONE : v_coord;
		end
		if (state_q == S_CV) begin
			x0_q <= dec_p0;
			x1_q <= dec_p1;
			fx_q <= dec_frac;
		end
		if (state_q == S_ROW0) begin
			y1_q <= dec_p1;
			fy_q <= dec_frac;
		end
		if (state_q == S_ROW1) begin
			row0_q <= acc_q[INDEX_W-1:0];
		end
		if (state_q == S_WSTART) begin
			row1_q <= acc_q[INDEX_W-1:0];
		end
		if (state_q == S_FETCH) begin
			tex_q[sel_q] <= ram_rd_data;
		end
		if (state_q == S_BLEND) begin
			if (step_q == BL_BOT_A) begin
				top_q <= acc_q[TOP_W-1:0];
			end
			if (step_q == BL_MIX_A) begin
				bot_q <= acc_q[TOP_W-1:0];
			end
			if (step_q == BL_STORE) begin
				case (ch_q)
					CH_RED:   res_red_q   <= acc_q[RES_LSB +: CHAN_W];
					CH_GREEN: res_green_q <= acc_q[RES_LSB +: CHAN_W];
					CH_BLUE:  res_blue_q  <= acc_q[RES_LSB +: CHAN_W];
					default:  res_blue_q  <= res_blue_q;
				endcase
			end
		end
		if ((state_q == S_OUT) && out_free) begin
			out_red   <= res_red_q;
			out_green <= res_green_q;
			out_blue  <= res_blue_q;
		end
	end

	bts_mac #(
		.WA (WA),
		.WB (WB)
	) u_mac (
		.clk   (clk),
		.ctl   (mac_ctl),
		.op_a  (mac_a),
		.op_b  (mac_b),
		.acc_q (acc_q)
	);

	bts_wrap #(
		.STORE_TEXELS (STORE_TEXELS)
	) u_wrap (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (wrap_req),
		.done   (wrap_done),
		.addr   (wrap_addr)
	);

	bts_ram #(
		.WIDTH (TEXEL_W),
		.DEPTH (STORE_TEXELS)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (wrap_addr),
		.rd_data (ram_rd_data)
	);

	// Every texel read lands inside the store.
	a_rd_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		ram_rd_en |-> (32'(wrap_addr) < STORE_TEXELS))
		else $error("texel read address beyond the store");

	// The wrap unit only finishes while the sequencer waits for it.
	a_wrap_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_done |-> (state_q == S_WRAP))
		else $error("address wrap finished outside the wait state");

	// The horizontal neighbour is the same or the next column and stays in the texture.
	a_x_neighbour: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROW0) |-> (((x1_q == x0_q) || (x1_q == x0_q + 8'd1)) && (x1_q <= w_m1)))
		else $error("horizontal neighbour out of range");

	// A finished channel blend fits in eight bits.
	a_blend_fits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_BLEND) && (step_q == BL_STORE)) |-> (acc_q[PW-1:RES_LSB+CHAN_W] == '0))
		else $error("channel blend exceeds eight bits");

endmodule

// ===== hdl/bts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bts_ram import bts_pkg::*; #(
	parameter int WIDTH = TEXEL_W,
	parameter int DEPTH = STORE_TEXELS_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/bts_mac.sv =====
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Forms one product per cycle and either starts or extends the accumulator.
// ----------------------------------------------------------------------------
module bts_mac import bts_pkg::*; #(
	parameter int WA = FRAC_BITS_DEF + CHAN_W,
	parameter int WB = FRAC_BITS_DEF + 1,
	localparam int PW = WA + WB
) (
	input  logic          clk,
	input  mac_ctl_t      ctl,
	input  logic [WA-1:0] op_a,
	input  logic [WB-1:0] op_b,
	output logic [PW-1:0] acc_q
);

	logic [PW-1:0] prod;

	assign prod = op_a * op_b;

	// The accumulation never holds more than two products that fit in PW bits.
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= (ctl.accum ? acc_q : '0) + prod;
		end
	end

endmodule

// ===== hdl/bts_wrap.sv =====
// ----------------------------------------------------------------------------
// Address wrap unit
// Reduces a 16-bit linear texel address modulo the store depth.
// ----------------------------------------------------------------------------
module bts_wrap import bts_pkg::*; #(
	parameter int STORE_TEXELS = STORE_TEXELS_DEF,
	localparam int AW = (STORE_TEXELS > 1) ? $clog2(STORE_TEXELS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  wrap_req_t     req,
	output logic          done,
	output logic [AW-1:0] addr
);

	localparam bit POW2     = (STORE_TEXELS & (STORE_TEXELS - 1)) == 0;
	localparam bit NEED_MOD = (STORE_TEXELS < LINEAR_SPAN) && (!POW2 || STORE_TEXELS == 1);

	generate
		if (NEED_MOD) begin : g_mod
			// A reciprocal multiply estimates the quotient into quot_s1. The
			// estimate is exact or one too small, so the remainder is then formed
			// into rem_q and the depth is subtracted from it at most once.
			localparam int                 RW    = $clog2(STORE_TEXELS + 1);
			localparam logic [32:0]        RECIP = 33'((64'd1 << 32) / STORE_TEXELS);
			localparam logic [INDEX_W-1:0] DIV_K = INDEX_W'(STORE_TEXELS);

			logic [INDEX_W-1:0]   val_s1;
			logic [INDEX_W-1:0]   quot_s1;
			logic                 done_s1;
			logic [RW-1:0]        rem_q;
			logic                 done_q;
			logic [INDEX_W+32:0]  prod;
			logic [2*INDEX_W-1:0] back_full;
			logic [INDEX_W-1:0]   raw;
			logic [INDEX_W-1:0]   fix;

			assign prod      = (INDEX_W + 33)'(req.value) * (INDEX_W + 33)'(RECIP);
			assign back_full = quot_s1 * DIV_K;
			assign raw       = val_s1 - back_full[INDEX_W-1:0];
			assign fix       = (raw >= DIV_K) ? raw - DIV_K : raw;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_s1 <= 1'b0;
					done_q  <= 1'b0;
				end else begin
					done_s1 <= req.start;
					done_q  <= done_s1;
				end
			end

			always_ff @(posedge clk) begin
				if (req.start) begin
					val_s1  <= req.value;
					quot_s1 <= prod[32 +: INDEX_W];
				end
				if (done_s1) begin
					rem_q <= RW'(fix);
				end
			end

			assign done = done_q;
			assign addr = AW'(rem_q);
		end else begin : g_pass
			// A power-of-two or large store needs only truncation or extension.
			logic [AW-1:0] addr_q;
			logic          done_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= req.start;
				end
			end

			always_ff @(posedge clk) begin
				if (req.start) begin
					addr_q <= AW'(req.value);
				end
			end

			assign done = done_q;
			assign addr = addr_q;
		end
	endgenerate

endmodule

// ===== tb/tb_bilinear_texture_sampler.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bilinear texture sampler testbench
// Loads texels into the texture store and samples them at many coordinates
// and texture sizes. A behavioral filter inside the bench mirrors the store
// and the size registers and predicts each filtered RGB result. The checker
// compares every returned transaction against the oldest prediction, field
// by field.
// ----------------------------------------------------------------------------
module tb_bilinear_texture_sampler;
	import bts_pkg::*;

	localparam int STORE_TEXELS  = STORE_TEXELS_DEF;
	localparam int FRAC_BITS     = FRAC_BITS_DEF;
	// Quiet cycles let pass after all predicted results are back. A write
	// produces no result, so these quiet cycles also cover the tail of any
	// transaction that is still in flight.
	localparam int SETTLE_CYCLES = 128;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic               kind;
		logic [INDEX_W-1:0] index;
		logic [CHAN_W-1:0]  red, green, blue;
		logic [COORD_W-1:0] u, v;
	} request_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red, green, blue;
	} color_t;

	// Linear store addresses of the four texels one sample blends.
	typedef logic [3:0][31:0] corner_set_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [DIM_W-1:0]   cfg_data;
	logic               req_valid;
	logic               req_stall;
	logic               kind;
	logic [INDEX_W-1:0] texel_index;
	logic [CHAN_W-1:0]  texel_red;
	logic [CHAN_W-1:0]  texel_green;
	logic [CHAN_W-1:0]  texel_blue;
	logic [COORD_W-1:0] u_coord;
	logic [COORD_W-1:0] v_coord;
	logic               rsp_valid;
	logic               rsp_stall;
	logic [CHAN_W-1:0]  out_red;
	logic [CHAN_W-1:0]  out_green;
	logic [CHAN_W-1:0]  out_blue;

	// Mirror of the block state. The store has no reset, so texel_loaded
	// records which entries were written; a sample is only sent once all of
	// its four texels are known.
	logic [TEXEL_W-1:0] texel_mirror [STORE_TEXELS];
	bit                 texel_loaded [STORE_TEXELS];
	logic [DIM_W-1:0]   width_reg;
	logic [DIM_W-1:0]   height_reg;

	// Filtered colors predicted for samples that were accepted but whose
	// result transaction has not come back yet, oldest first.
	color_t pending_colors [$];

	int mismatch_count = 0;
	int cycle_count = 0;
	int req_gap_pct;
	int rsp_hold_pct;

	bilinear_texture_sampler #(
		.STORE_TEXELS (STORE_TEXELS),
		.FRAC_BITS    (FRAC_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.texel_index (texel_index),
		.texel_red   (texel_red),
		.texel_green (texel_green),
		.texel_blue  (texel_blue),
		.u_coord     (u_coord),
		.v_coord     (v_coord),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// A size register of zero behaves as one texel, anything above 256 as 256.
	function automatic int unsigned effective_dim(input logic [DIM_W-1:0] d);
		int unsigned r;
		r = d;
		if (r == 0) begin
			r = 1;
		end else if (r > 256) begin
			r = 256;
		end
		return r;
	endfunction

	// Scales one coordinate onto the texture axis. The integer part gives the
	// base texel, the next texel is its neighbour (held at the last column or
	// row), and the low 16 bits become the blend weight at FRAC_BITS
	// precision. A coordinate of exactly 1.0 lands on the last texel with a
	// zero weight, and anything above 1.0 is treated as 1.0.
	function automatic void split_axis(input logic [COORD_W-1:0] c, input int unsigned dim,
			output int unsigned lo, output int unsigned hi, output longint unsigned wt);
		int unsigned cc;
		int unsigned pos;
		int unsigned frac;
		cc = (c > COORD_ONE) ? COORD_ONE : c;
		pos = cc * (dim - 1);
		lo = pos >> 16;
		frac = pos & 32'hFFFF;
		hi = lo;
		wt = 0;
		if (cc != COORD_ONE) begin
			hi = (lo + 1 > dim - 1) ? dim - 1 : lo + 1;
			if (FRAC_BITS >= 16) begin
				wt = longint'(frac) << (FRAC_BITS - 16);
			end else begin
				wt = longint'(frac) >> (16 - FRAC_BITS);
			end
		end
	endfunction

	// Addresses of the corner texels in the order top-left, top-right,
	// bottom-left, bottom-right, plus the two axis weights.
	function automatic void sample_corners(input logic [COORD_W-1:0] u, v,
			output corner_set_t addr, output longint unsigned fx, output longint unsigned fy);
		int unsigned w, h, x0, x1, y0, y1;
		w = effective_dim(width_reg);
		h = effective_dim(height_reg);
		split_axis(u, w, x0, x1, fx);
		split_axis(v, h, y0, y1, fy);
		addr[0] = (y0 * w + x0) % STORE_TEXELS;
		addr[1] = (y0 * w + x1) % STORE_TEXELS;
		addr[2] = (y1 * w + x0) % STORE_TEXELS;
		addr[3] = (y1 * w + x1) % STORE_TEXELS;
	endfunction

	// Exact bilinear blend with 2*FRAC_BITS fraction bits, truncated to a byte
	// per channel. Red sits in the top byte of a texel, blue in the bottom.
	function automatic color_t filter_texels(input logic [COORD_W-1:0] u, v);
		corner_set_t       addr;
		longint unsigned   fx, fy, one, a, b, c, d, top, bottom, sum;
		logic [3*CHAN_W-1:0] rgb;
		int                ch;
		int                sh;
		sample_corners(u, v, addr, fx, fy);
		one = 64'd1 << FRAC_BITS;
		for (ch = 0; ch < 3; ch++) begin
			sh = 16 - 8 * ch;
			a = (texel_mirror[addr[0]] >> sh) & 8'hFF;
			b = (texel_mirror[addr[1]] >> sh) & 8'hFF;
			c = (texel_mirror[addr[2]] >> sh) & 8'hFF;
			d = (texel_mirror[addr[3]] >> sh) & 8'hFF;
			top = a * (one - fx) + b * fx;
			bottom = c * (one - fx) + d * fx;
			sum = top * (one - fy) + bottom * fy;
			rgb[sh +: CHAN_W] = CHAN_W'(sum >> (2 * FRAC_BITS));
		end
		return color_t'(rgb);
	endfunction

	function automatic logic [COORD_W-1:0] random_coord();
		logic [COORD_W-1:0] c;
		case ($urandom_range(9))
			0: c = COORD_ONE;
			1: c = '0;
			2: c = COORD_W'($urandom_range(32'h1FFFF, 32'h10001));
			3: c = COORD_W'($urandom);
			default: c = COORD_W'($urandom_range(32'h10000));
		endcase
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Drives one transaction, holding it until it is accepted, and then
	// applies it to the mirror: a write updates the store, a sample queues
	// its predicted color. Valid stays high on return so that the next
	// transaction can follow back to back.
	task automatic send_item(input request_t r);
		if ($urandom_range(99) < req_gap_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < req_gap_pct);
		end
		req_valid   <= 1'b1;
		kind        <= r.kind;
		texel_index <= r.index;
		texel_red   <= r.red;
		texel_green <= r.green;
		texel_blue  <= r.blue;
		u_coord     <= r.u;
		v_coord     <= r.v;
		do @(posedge clk); while (req_stall);
		if (r.kind == KIND_WRITE) begin
			// An index beyond the store is dropped by the block.
			if (int'(r.index) < STORE_TEXELS) begin
				texel_mirror[r.index] = {r.red, r.green, r.blue};
				texel_loaded[r.index] = 1'b1;
			end
		end else begin
			pending_colors.push_back(filter_texels(r.u, r.v));
		end
	endtask

	task automatic write_texel(input logic [INDEX_W-1:0] idx, input logic [TEXEL_W-1:0] rgb);
		request_t r;
		r.kind = KIND_WRITE;
		r.index = idx;
		{r.red, r.green, r.blue} = rgb;
		// The coordinates mean nothing to a write; random values show that.
		r.u = COORD_W'($urandom);
		r.v = COORD_W'($urandom);
		send_item(r);
	endtask

	// Any corner texel that was never written gets a random color first, so
	// the sample never reads an undefined store entry.
	task automatic sample_at(input logic [COORD_W-1:0] u, v);
		request_t        r;
		corner_set_t     addr;
		longint unsigned fx, fy;
		int              i;
		sample_corners(u, v, addr, fx, fy);
		for (i = 0; i < 4; i++) begin
			if (!texel_loaded[addr[i]]) begin
				write_texel(addr[i][INDEX_W-1:0], TEXEL_W'($urandom));
			end
		end
		r.kind = KIND_SAMPLE;
		// Index and color are ignored on a sample; keep them moving anyway.
		r.index = INDEX_W'($urandom);
		{r.red, r.green, r.blue} = TEXEL_W'($urandom);
		r.u = u;
		r.v = v;
		send_item(r);
	endtask

	// Drops valid, waits for every predicted result to come back and then
	// lets the given number of quiet cycles pass.
	task automatic settle(input int tail_cycles);
		req_valid <= 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
		repeat (tail_cycles) @(posedge clk);
	endtask

	// The size registers may only change while the block is idle.
	task automatic set_dims(input logic [DIM_W-1:0] w, h);
		settle(SETTLE_CYCLES);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TEX_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= CFG_TEX_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		width_reg = w;
		height_reg = h;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Runs on the reset size of 256 by 256, before any register write.
	task automatic test_reset_dims();
		write_texel(16'd0, 24'h000000);
		write_texel(16'd1, 24'hFFFFFF);
		write_texel(16'd256, 24'hFF00FF);
		write_texel(16'd257, 24'h00FF00);
		write_texel(16'hFFFF, 24'hFFFFFF);
		sample_at('0, '0);
		// Weights close to one on both axes across the four texels above.
		sample_at(17'h00100, 17'h00100);
		// Exactly 1.0 picks the last texel with no neighbour contribution.
		sample_at(COORD_ONE, COORD_ONE);
		// Beyond 1.0 saturates to the same texel.
		sample_at(17'h1FFFF, 17'h1FFFF);
		sample_at(COORD_ONE, '0);
	endtask

	// Degenerate and clamped texture sizes, where the neighbour falls off
	// the edge and is held at the last column or row.
	task automatic test_dim_extremes();
		set_dims(DIM_MIN, DIM_MIN);
		sample_at(17'h08000, 17'h08000);
		sample_at(COORD_ONE, 17'h1FFFF);
		// A zero width acts as one column, an all-ones height as 256 rows.
		set_dims('0, 9'h1FF);
		sample_at(17'h1FFFF, 17'h08000);
		sample_at(17'h0FFFF, COORD_ONE);
		set_dims(DIM_MAX, DIM_MIN);
		sample_at(17'h0FFFF, 17'h0FFFF);
		set_dims(9'd2, 9'd2);
		sample_at(17'h08000, 17'h08000);
		sample_at(17'h0FFFF, 17'h00001);
	endtask

	// Random writes and samples over several texture sizes. Halfway through
	// each size the sender holds off until all results are back.
	task automatic test_random(input int settings, input int per_setting);
		logic [DIM_W-1:0] w, h;
		int unsigned      area;
		int               s, i;
		for (s = 0; s < settings; s++) begin
			case ($urandom_range(3))
				0: begin
					w = DIM_W'($urandom_range(16, 1));
					h = DIM_W'($urandom_range(16, 1));
				end
				1: begin
					w = DIM_W'($urandom_range(511));
					h = DIM_W'($urandom_range(511));
				end
				2: begin
					w = $urandom_range(1) ? DIM_MAX : DIM_MIN;
					h = $urandom_range(1) ? DIM_MAX : DIM_MIN;
				end
				default: begin
					w = DIM_W'($urandom_range(64, 1));
					h = DIM_W'($urandom_range(64, 1));
				end
			endcase
			set_dims(w, h);
			area = effective_dim(w) * effective_dim(h);
			for (i = 0; i < per_setting; i++) begin
				if (i == per_setting / 2) begin
					settle(1);
				end
				if ($urandom_range(99) < 45) begin
					// Half the writes land inside the texture, the rest anywhere.
					if ($urandom_range(1)) begin
						write_texel(INDEX_W'($urandom_range(area - 1)), TEXEL_W'($urandom));
					end else begin
						write_texel(INDEX_W'($urandom), TEXEL_W'($urandom));
					end
				end else begin
					sample_at(random_coord(), random_coord());
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Response side
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
	end

	// Every accepted result transaction is matched against the oldest
	// prediction. Only the first few mismatches are printed.
	always @(posedge clk) begin
		color_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_colors.size() == 0) begin
				if (mismatch_count < MAX_REPORTS) begin
					$display("%0t: result with no sample pending: r=%0d g=%0d b=%0d",
						$realtime, out_red, out_green, out_blue);
				end
				mismatch_count++;
			end else begin
				want = pending_colors.pop_front();
				if (want.red !== out_red || want.green !== out_green ||
						want.blue !== out_blue) begin
					if (mismatch_count < MAX_REPORTS) begin
						$display("%0t: color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
							$realtime, want.red, want.green, want.blue,
							out_red, out_green, out_blue);
					end
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: no progress after %0d cycles, %0d results outstanding",
				$realtime, cycle_count, pending_colors.size());
			$display("bilinear_texture_sampler verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= CFG_TEX_WIDTH;
		cfg_data    <= '0;
		req_valid   <= 1'b0;
		kind        <= KIND_WRITE;
		texel_index <= '0;
		texel_red   <= '0;
		texel_green <= '0;
		texel_blue  <= '0;
		u_coord     <= '0;
		v_coord     <= '0;
		width_reg = DIM_MAX;
		height_reg = DIM_MAX;

		// Light gaps on the request side, heavy back-pressure on results.
		req_gap_pct = 9;
		rsp_hold_pct = 68;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_dims();
		test_dim_extremes();
		test_random(3, 55);

		// Now a slow sender and a mostly ready receiver.
		req_gap_pct = 68;
		rsp_hold_pct = 9;
		test_random(3, 55);

		// Full speed on both sides.
		req_gap_pct = 0;
		rsp_hold_pct = 0;
		test_random(3, 55);

		settle(SETTLE_CYCLES);
		if (mismatch_count == 0) begin
			$display("bilinear_texture_sampler verification clean");
		end else begin
			$display("bilinear_texture_sampler verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/bts_pkg.sv
hdl/bts_ram.sv
hdl/bts_mac.sv
hdl/bts_wrap.sv
hdl/bilinear_texture_sampler.sv
tb/tb_bilinear_texture_sampler.sv
